// ===== src/mla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mipmap atlas address package
// Shared widths, register indexes and transaction types for the mipmap level
// selection and packed atlas address block.
// ----------------------------------------------------------------------------
package mla_pkg;

    localparam int COORD_W = 12;   // source left and top edges
    localparam int DIM_W   = 13;   // widths, heights and atlas coordinates
    localparam int LEVEL_W = 4;    // mipmap level
    localparam int CFG_IDX_W = 1;

    // The widest atlas width is 1.5 times a full-scale register, which needs
    // one bit more than a dimension. Every bit of it is one candidate level.
    localparam int ATLAS_W    = DIM_W + 1;
    localparam int NUM_LEVELS = ATLAS_W;

    // Product of a height and the largest level scale factor.
    localparam int SCALE_W = DIM_W + NUM_LEVELS - 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'b1;

    typedef struct packed {
        logic               src_given;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [DIM_W-1:0]   src_w;
        logic [DIM_W-1:0]   src_h;
        logic               dst_given;
        logic [DIM_W-1:0]   dst_w;
        logic [DIM_W-1:0]   dst_h;
    } req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DIM_W-1:0]   area_x;
        logic [DIM_W-1:0]   area_y;
        logic [DIM_W-1:0]   area_w;
        logic [DIM_W-1:0]   area_h;
    } rsp_t;

endpackage

// ===== src/mla_level_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mipmap level selector
// Compares the destination size against every halving of the source size in
// parallel and picks the first level at which the destination is larger.
// ----------------------------------------------------------------------------
module mla_level_sel
    import mla_pkg::*;
(
    input  logic [DIM_W-1:0]   tex_width,
    input  logic [DIM_W-1:0]   tex_height,
    input  logic               dst_given,
    input  logic [DIM_W-1:0]   src_w,
    input  logic [DIM_W-1:0]   src_h,
    input  logic [DIM_W-1:0]   dst_w,
    input  logic [DIM_W-1:0]   dst_h,
    output logic [LEVEL_W-1:0] level
);

    logic [ATLAS_W-1:0]    atlas_w;
    logic [ATLAS_W-1:0]    span;
    logic [NUM_LEVELS-1:0] hit;
    logic [NUM_LEVELS-1:0] first_hit;

    assign atlas_w = {1'b0, tex_width} + {2'b00, tex_width[DIM_W-1:1]};
    assign span    = (atlas_w > {1'b0, tex_height}) ? atlas_w : {1'b0, tex_height};

    // A level exists only while the larger atlas side still has a bit at or
    // above its position.
    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            hit[i] = dst_given && ((span >> i) != '0) &&
                     ((dst_w > (src_w >> (i + 1))) || (dst_h > (src_h >> (i + 1))));
        end
    end

    assign first_hit = hit & (~hit + 1'b1);

    always_comb begin
        level = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (first_hit[i]) begin
                level = level | LEVEL_W'(i);
            end
        end
    end

endmodule

// ===== src/mipmap_level_atlas_address.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mipmap level atlas address
// Selects a mipmap level for a sprite copy and returns the rectangle to read
// from a packed mipmap atlas.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock unless both its registers hold
// data and the result side is stalled, and returns one result per transaction.
// Each transaction is held in an input register; the level tests for
// all levels run side by side, and the atlas offset and shifted rectangle are
// formed in the same cycle and captured in the output register. A result
// waiting in the output register does not stop the block from taking a new
// transaction: the input register fills behind it. The level is the first one
// at which the destination width or height exceeds the source side halved once
// more, limited by the bit length of the larger atlas side; it is zero when no
// destination size is given or no level matches. When src_given is low the
// whole base texture is used as the source. Level 0 sits at the atlas origin
// and level k from 1 upwards sits at x = tex_width,
// y = ((2^(k-1) - 1) * tex_height) >> (k-1). Atlas coordinates wrap at 13 bits.
// The texture size registers must only be written while no transaction is in
// flight; they are applied without clamping.
// ----------------------------------------------------------------------------
module mipmap_level_atlas_address
    import mla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_src_given,
    input  logic [COORD_W-1:0]   s_src_x,
    input  logic [COORD_W-1:0]   s_src_y,
    input  logic [DIM_W-1:0]     s_src_w,
    input  logic [DIM_W-1:0]     s_src_h,
    input  logic                 s_dst_given,
    input  logic [DIM_W-1:0]     s_dst_w,
    input  logic [DIM_W-1:0]     s_dst_h,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEVEL_W-1:0]   m_level,
    output logic [DIM_W-1:0]     m_area_x,
    output logic [DIM_W-1:0]     m_area_y,
    output logic [DIM_W-1:0]     m_area_w,
    output logic [DIM_W-1:0]     m_area_h
);

    // Texture size registers.
    logic [DIM_W-1:0] tex_width_reg;
    logic [DIM_W-1:0] tex_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= '0;
            tex_height_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_wdata;
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Handshake. The output register may take a new result when it is empty
    // or its result is being taken; the input register may take a new
    // transaction when it is empty or its contents move on.
    logic req_valid_reg;
    req_t req_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_load;

    assign rsp_load = !rsp_valid_reg || m_ready;
    assign s_ready  = !req_valid_reg || rsp_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg.src_given <= s_src_given;
            req_reg.src_x     <= s_src_x;
            req_reg.src_y     <= s_src_y;
            req_reg.src_w     <= s_src_w;
            req_reg.src_h     <= s_src_h;
            req_reg.dst_given <= s_dst_given;
            req_reg.dst_w     <= s_dst_w;
            req_reg.dst_h     <= s_dst_h;
        end
    end

    // Source rectangle: the request's own, or the whole base texture.
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;

    always_comb begin
        if (req_reg.src_given) begin
            src_x = req_reg.src_x;
            src_y = req_reg.src_y;
            src_w = req_reg.src_w;
            src_h = req_reg.src_h;
        end else begin
            src_x = '0;
            src_y = '0;
            src_w = tex_width_reg;
            src_h = tex_height_reg;
        end
    end

    logic [LEVEL_W-1:0] level;

    mla_level_sel u_level_sel (
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .dst_given  (req_reg.dst_given),
        .src_w      (src_w),
        .src_h      (src_h),
        .dst_w      (req_reg.dst_w),
        .dst_h      (req_reg.dst_h),
        .level      (level)
    );

    // Atlas origin of the chosen level. The vertical offset is the height
    // scaled by (2^k - 1) / 2^k with k one less than the level, formed with shifts and a subtraction.
    logic [LEVEL_W-1:0] lvl_k;
    logic [SCALE_W-1:0] height_ext;
    logic [SCALE_W-1:0] scaled;
    logic [DIM_W-1:0]   base_x;
    logic [DIM_W-1:0]   base_y;

    assign lvl_k      = level - 1'b1;
    assign height_ext = {{(SCALE_W-DIM_W){1'b0}}, tex_height_reg};
    assign scaled     = (height_ext << lvl_k) - height_ext;

    always_comb begin
        if (level != '0) begin
            base_x = tex_width_reg;
            base_y = DIM_W'(scaled >> lvl_k);
        end else begin
            base_x = '0;
            base_y = '0;
        end
    end

    always_comb begin
        rsp_next.level  = level;
        rsp_next.area_x = base_x + ({1'b0, src_x} >> level);
        rsp_next.area_y = base_y + ({1'b0, src_y} >> level);
        rsp_next.area_w = src_w >> level;
        rsp_next.area_h = src_h >> level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (rsp_load) begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_load && req_valid_reg) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid  = rsp_valid_reg;
    assign m_level  = rsp_reg.level;
    assign m_area_x = rsp_reg.area_x;
    assign m_area_y = rsp_reg.area_y;
    assign m_area_w = rsp_reg.area_w;
    assign m_area_h = rsp_reg.area_h;

    // Without a destination size the level must come out as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp_load && req_valid_reg && !req_reg.dst_given) |=> (m_level == '0))
        else $error("level not zero without a destination size");

    // At level zero the read rectangle has the full source size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp_load && req_valid_reg && level == '0) |=> (m_area_w == $past(src_w)))
        else $error("level zero rectangle width differs from source width");

    // The input side only stalls while a transaction waits in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (req_valid_reg && rsp_valid_reg))
        else $error("input stalled with room in the pipeline");

    // The level never goes beyond the last candidate level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level < LEVEL_W'(NUM_LEVELS)))
        else $error("level out of range");

endmodule

// ===== tb/mipmap_level_atlas_address_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mipmap level atlas address checker
// Watches the configuration port and both transaction channels of the block,
// works out the level and atlas rectangle for every accepted request and
// compares each returned result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module mipmap_level_atlas_address_check
    import mla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_src_given,
    input  logic [COORD_W-1:0]   s_src_x,
    input  logic [COORD_W-1:0]   s_src_y,
    input  logic [DIM_W-1:0]     s_src_w,
    input  logic [DIM_W-1:0]     s_src_h,
    input  logic                 s_dst_given,
    input  logic [DIM_W-1:0]     s_dst_w,
    input  logic [DIM_W-1:0]     s_dst_h,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [LEVEL_W-1:0]   m_level,
    input  logic [DIM_W-1:0]     m_area_x,
    input  logic [DIM_W-1:0]     m_area_y,
    input  logic [DIM_W-1:0]     m_area_w,
    input  logic [DIM_W-1:0]     m_area_h,

    output int                   mismatches,
    output int                   outstanding
);

    logic [DIM_W-1:0] tex_w;
    logic [DIM_W-1:0] tex_h;
    rsp_t             expected_area[$];
    int               fail_count = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic rsp_t predict_area(input req_t r);
        logic [DIM_W-1:0]   sw;
        logic [DIM_W-1:0]   sh;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [DIM_W-1:0]   bx;
        logic [ATLAS_W-1:0] span;
        logic [63:0]        by;
        int unsigned        n_levels;
        int unsigned        lvl;
        int unsigned        k;
        bit                 found;
        rsp_t               o;

        if (r.src_given) begin
            sx = r.src_x;
            sy = r.src_y;
            sw = r.src_w;
            sh = r.src_h;
        end else begin
            sx = '0;
            sy = '0;
            sw = tex_w;
            sh = tex_h;
        end

        lvl = 0;
        if (r.dst_given) begin
            // Number of candidate levels is the bit length of the larger atlas side.
            span = {1'b0, tex_w} + (tex_w >> 1);
            if ({1'b0, tex_h} > span)
                span = {1'b0, tex_h};
            n_levels = 0;
            while (span != 0) begin
                n_levels++;
                span = span >> 1;
            end
            found = 1'b0;
            for (int i = 0; i < n_levels; i++) begin
                if (!found && (r.dst_w > (sw >> (i + 1)) || r.dst_h > (sh >> (i + 1)))) begin
                    lvl   = i;
                    found = 1'b1;
                end
            end
        end

        bx = '0;
        by = '0;
        if (lvl != 0) begin
            k  = lvl - 1;
            bx = tex_w;
            by = (((64'd1 << k) - 64'd1) * {51'd0, tex_h}) >> k;
        end

        o.level  = LEVEL_W'(lvl);
        o.area_x = bx + DIM_W'(sx >> lvl);
        o.area_y = by[DIM_W-1:0] + DIM_W'(sy >> lvl);
        o.area_w = sw >> lvl;
        o.area_h = sh >> lvl;
        return o;
    endfunction

    always @(posedge aclk) begin
        req_t req;
        rsp_t want;

        if (!aresetn) begin
            tex_w = '0;
            tex_h = '0;
            expected_area.delete();
        end else begin
            if (cfg_wen) begin
                if (cfg_index == CFG_TEX_WIDTH)
                    tex_w = cfg_wdata;
                else if (cfg_index == CFG_TEX_HEIGHT)
                    tex_h = cfg_wdata;
            end

            // A result leaving at this edge belongs to an earlier request, so
            // it is matched before any request taken at the same edge.
            if (m_valid && m_ready) begin
                if (expected_area.size() == 0) begin
                    report_mismatch("result returned with no request waiting");
                end else begin
                    want = expected_area.pop_front();
                    if (m_level !== want.level)
                        report_mismatch($sformatf("level got %0d want %0d",
                                                  m_level, want.level));
                    if (m_area_x !== want.area_x)
                        report_mismatch($sformatf("area_x got %0d want %0d",
                                                  m_area_x, want.area_x));
                    if (m_area_y !== want.area_y)
                        report_mismatch($sformatf("area_y got %0d want %0d",
                                                  m_area_y, want.area_y));
                    if (m_area_w !== want.area_w)
                        report_mismatch($sformatf("area_w got %0d want %0d",
                                                  m_area_w, want.area_w));
                    if (m_area_h !== want.area_h)
                        report_mismatch($sformatf("area_h got %0d want %0d",
                                                  m_area_h, want.area_h));
                end
            end

            if (s_valid && s_ready) begin
                req.src_given = s_src_given;
                req.src_x     = s_src_x;
                req.src_y     = s_src_y;
                req.src_w     = s_src_w;
                req.src_h     = s_src_h;
                req.dst_given = s_dst_given;
                req.dst_w     = s_dst_w;
                req.dst_h     = s_dst_h;
                expected_area.push_back(predict_area(req));
            end
        end
        outstanding <= expected_area.size();
    end

endmodule

// ===== tb/mipmap_level_atlas_address_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mipmap level atlas address testbench
// Drives sprite-copy requests into the block under a range of texture sizes,
// with random gaps and result-side stalls, and lets the checker judge every
// result against its own prediction of level and atlas rectangle.
// ----------------------------------------------------------------------------
module mipmap_level_atlas_address_test;
    import mla_pkg::*;

    // Random requests per texture setting; eight settings give roughly 500.
    localparam int PHASE_ITEMS = 62;
    localparam int NUM_PHASES  = 8;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TEX_WIDTH;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_src_given = 1'b0;
    logic [COORD_W-1:0]   s_src_x = '0;
    logic [COORD_W-1:0]   s_src_y = '0;
    logic [DIM_W-1:0]     s_src_w = '0;
    logic [DIM_W-1:0]     s_src_h = '0;
    logic                 s_dst_given = 1'b0;
    logic [DIM_W-1:0]     s_dst_w = '0;
    logic [DIM_W-1:0]     s_dst_h = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [LEVEL_W-1:0]   m_level;
    logic [DIM_W-1:0]     m_area_x;
    logic [DIM_W-1:0]     m_area_y;
    logic [DIM_W-1:0]     m_area_w;
    logic [DIM_W-1:0]     m_area_h;

    int                   mismatches;
    int                   outstanding;

    // Texture size currently programmed, so that whole-texture requests can
    // be aimed at particular levels.
    int unsigned          tex_w_now = 0;
    int unsigned          tex_h_now = 0;

    // While set, neither side inserts gaps or stalls: back-to-back traffic.
    bit                   calm = 1'b0;

    always #5 aclk = ~aclk;

    mipmap_level_atlas_address dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_src_given (s_src_given),
        .s_src_x     (s_src_x),
        .s_src_y     (s_src_y),
        .s_src_w     (s_src_w),
        .s_src_h     (s_src_h),
        .s_dst_given (s_dst_given),
        .s_dst_w     (s_dst_w),
        .s_dst_h     (s_dst_h),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_area_x    (m_area_x),
        .m_area_y    (m_area_y),
        .m_area_w    (m_area_w),
        .m_area_h    (m_area_h)
    );

    mipmap_level_atlas_address_check checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_src_given (s_src_given),
        .s_src_x     (s_src_x),
        .s_src_y     (s_src_y),
        .s_src_w     (s_src_w),
        .s_src_h     (s_src_h),
        .s_dst_given (s_dst_given),
        .s_dst_w     (s_dst_w),
        .s_dst_h     (s_dst_h),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_area_x    (m_area_x),
        .m_area_y    (m_area_y),
        .m_area_w    (m_area_w),
        .m_area_h    (m_area_h),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic req_t make_req(input bit sg, input int unsigned x, input int unsigned y,
                                      input int unsigned w, input int unsigned h,
                                      input bit dg, input int unsigned dw,
                                      input int unsigned dh);
        req_t r;
        r.src_given = sg;
        r.src_x     = COORD_W'(x);
        r.src_y     = COORD_W'(y);
        r.src_w     = DIM_W'(w);
        r.src_h     = DIM_W'(h);
        r.dst_given = dg;
        r.dst_w     = DIM_W'(dw);
        r.dst_h     = DIM_W'(dh);
        return r;
    endfunction

    // Most requests aim at a chosen level: one destination side is made just
    // larger than the source side halved (level + 1) times, while the other
    // stays within its bound. A tenth are pure noise over the full field
    // widths, a tenth use the whole texture and a tenth give no destination.
    function automatic req_t random_request();
        req_t        r;
        int unsigned kind;
        int unsigned lvl;
        int unsigned sw;
        int unsigned sh;

        kind = $urandom_range(0, 9);
        lvl  = $urandom_range(0, 12);
        sw   = $urandom_range(0, 4096);
        sh   = $urandom_range(0, 4096);
        if (kind == 0) begin
            sw = $urandom_range(0, 8191);
            sh = $urandom_range(0, 8191);
        end
        r = make_req(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095), sw, sh,
                     kind != 2, 0, 0);
        if (kind == 1) begin
            // The source fields still carry random values, which must be ignored.
            r.src_given = 1'b0;
            sw = tex_w_now;
            sh = tex_h_now;
        end
        if (kind == 0 || kind == 2) begin
            r.dst_w = DIM_W'($urandom_range(0, 8191));
            r.dst_h = DIM_W'($urandom_range(0, 8191));
        end else if ($urandom_range(0, 1) == 1) begin
            r.dst_w = DIM_W'((sw >> (lvl + 1)) + 1);
            r.dst_h = DIM_W'($urandom_range(0, sh >> (lvl + 1)));
        end else begin
            r.dst_w = DIM_W'($urandom_range(0, sw >> (lvl + 1)));
            r.dst_h = DIM_W'((sh >> (lvl + 1)) + 1);
        end
        return r;
    endfunction

    // Offers one request after a random gap and returns at the edge where the
    // transaction is taken. Valid is only touched once per edge, so a request
    // following without a gap keeps valid high throughout.
    task automatic send_request(input req_t r);
        int unsigned gap;

        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_src_given <= r.src_given;
        s_src_x     <= r.src_x;
        s_src_y     <= r.src_y;
        s_src_w     <= r.src_w;
        s_src_h     <= r.src_h;
        s_dst_given <= r.dst_given;
        s_dst_w     <= r.dst_w;
        s_dst_h     <= r.dst_h;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Drops valid and waits until every expected result has been returned,
    // then waits on so that the two-stage pipeline is certainly
    // empty. The first edge lets the checker's count catch up with a
    // transaction taken at the edge just passed.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the width register and then the height register; the write
    // enable stays high across both writes and falls once.
    task automatic set_texture(input int unsigned w, input int unsigned h);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_TEX_WIDTH;
        cfg_wdata <= DIM_W'(w);
        @(posedge aclk);
        cfg_index <= CFG_TEX_HEIGHT;
        cfg_wdata <= DIM_W'(h);
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        tex_w_now = w;
        tex_h_now = h;
        @(posedge aclk);
    endtask

    // Short directed set, run with a 4096 by 4096 texture: whole-texture and
    // no-destination requests, no level matching, all-zero and all-ones
    // fields, then one request aimed at each level from 0 to 12, triggered
    // alternately by the width and by the height.
    task automatic run_directed();
        int unsigned bound;

        send_request(make_req(1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_request(make_req(1'b0, 0, 0, 0, 0, 1'b1, 1, 1));
        send_request(make_req(1'b1, 4095, 4095, 4096, 4096, 1'b1, 0, 0));
        send_request(make_req(1'b1, 0, 0, 0, 0, 1'b1, 0, 0));
        send_request(make_req(1'b1, 0, 0, 0, 0, 1'b1, 1, 0));
        send_request(make_req(1'b1, 4095, 4095, 8191, 8191, 1'b1, 8191, 8191));
        send_request(make_req(1'b1, 4095, 4095, 8191, 8191, 1'b0, 8191, 8191));
        for (int lvl = 0; lvl <= 12; lvl++) begin
            bound = (4096 >> (lvl + 1)) + 1;
            if (lvl % 2 == 0)
                send_request(make_req(1'b1, $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), 4096, 4096, 1'b1, bound, 0));
            else
                send_request(make_req(1'b1, $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), 4096, 4096, 1'b1, 0, bound));
        end
    endtask

    // Result side: before each result, ready may be held low for a random stall,
    // except during calm stretches.
    initial begin
        int unsigned stall;

        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready))
                @(posedge aclk);
        end
    end

    // Texture settings: full scale, empty, the smallest, the largest the
    // registers hold (so atlas coordinates wrap), one side empty each way,
    // then two random sizes.
    initial begin
        int unsigned phase_w[NUM_PHASES];
        int unsigned phase_h[NUM_PHASES];

        phase_w = '{4096, 0, 1, 8191, 4096, 0, 0, 0};
        phase_h = '{4096, 0, 1, 8191, 0, 4096, 0, 0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= 6) begin
                phase_w[p] = $urandom_range(2, 4096);
                phase_h[p] = $urandom_range(2, 4096);
            end
            set_texture(phase_w[p], phase_h[p]);
            if (p == 0)
                run_directed();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Every so often switch between idling and back-to-back traffic.
                if (n % 20 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_request(random_request());
            end
            calm = 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("[mipmap_level_atlas_address] OK");
        else
            $display("[mipmap_level_atlas_address] ERROR");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("[mipmap_level_atlas_address] ERROR");
        $finish;
    end

endmodule

// ===== mipmap_level_atlas_address.f =====
src/mla_pkg.sv
src/mla_level_sel.sv
src/mipmap_level_atlas_address.sv
tb/mipmap_level_atlas_address_check.sv
tb/mipmap_level_atlas_address_test.sv
